[rtl/hcbd_pkg.sv]
package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEF = 32;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  typedef enum logic [1:0] {
    PH_SIZE   = 2'd0,
    PH_BODY   = 2'd1,
    PH_FOOTER = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SP_BLANKS = 2'd0,
    SP_DIGITS = 2'd1,
    SP_REST   = 2'd2
  } parse_stage_t;

  typedef enum logic [1:0] {
    STAT_RUN   = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_TRUNC = 2'd2,
    STAT_OVFL  = 2'd3
  } status_t;

  // decoder control state apart from the size counter
  typedef struct packed {
    phase_t       phase;
    logic         last_chunk_seen;
    parse_stage_t size_parse_stage;
    logic [1:0]   line_char_count;
    logic         previous_was_cr;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{
    phase:            PH_SIZE,
    last_chunk_seen:  1'b0,
    size_parse_stage: SP_BLANKS,
    line_char_count:  2'd0,
    previous_was_cr:  1'b0
  };

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      // letters a-f and A-F share the low nibble 1..6
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

[rtl/hcbd_if.sv]
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source(output valid, output action, output data_byte, input ready);
  modport sink(input valid, input action, input data_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic       body_valid;
  logic [7:0] body_byte;
  logic [1:0] status;

  modport source(output valid, output body_valid, output body_byte, output status,
                 input ready);
  modport sink(input valid, input body_valid, input body_byte, input status,
               output ready);
endinterface

[rtl/hcbd_step.sv]
module hcbd_step #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  hcbd_pkg::ctrl_t   ctrl,
  input  logic [SIZE_BITS-1:0] chunk_remaining,
  input  logic              action,
  input  logic [7:0]        data_byte,
  output hcbd_pkg::ctrl_t   ctrl_next,
  output logic [SIZE_BITS-1:0] chunk_remaining_next,
  output logic              body_valid,
  output logic [7:0]        body_byte,
  output hcbd_pkg::status_t status
);
  import hcbd_pkg::*;

  logic [SIZE_BITS-1:0] rem_dec;
  logic                 lf;
  logic                 empty_line;

  assign rem_dec    = chunk_remaining - SIZE_BITS'(1);
  assign lf         = (data_byte == CH_LF);
  assign empty_line = (ctrl.line_char_count == 2'd0) ||
                      ((ctrl.line_char_count == 2'd1) && ctrl.previous_was_cr);

  always_comb begin
    ctrl_next            = ctrl;
    chunk_remaining_next = chunk_remaining;
    body_valid           = 1'b0;
    body_byte            = 8'd0;
    status               = STAT_RUN;

    if (action) begin
      ctrl_next            = CTRL_RESET;
      chunk_remaining_next = '0;
      status               = STAT_TRUNC;
    end else begin
      case (ctrl.phase)
        PH_SIZE: begin
          if (lf) begin
            if (chunk_remaining == '0) begin
              ctrl_next.phase           = PH_FOOTER;
              ctrl_next.last_chunk_seen = 1'b1;
            end else begin
              ctrl_next.phase = PH_BODY;
            end
            ctrl_next.size_parse_stage = SP_BLANKS;
            ctrl_next.line_char_count  = 2'd0;
            ctrl_next.previous_was_cr  = 1'b0;
          end else if (ctrl.size_parse_stage == SP_BLANKS && is_blank(data_byte)) begin
            ctrl_next = ctrl;
          end else if (ctrl.size_parse_stage != SP_REST) begin
            if (!is_hex(data_byte)) begin
              ctrl_next.size_parse_stage = SP_REST;
            end else if (chunk_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
              // one more digit would not fit
              ctrl_next            = CTRL_RESET;
              chunk_remaining_next = '0;
              status               = STAT_OVFL;
            end else begin
              chunk_remaining_next = {chunk_remaining[SIZE_BITS-5:0], hex_value(data_byte)};
              ctrl_next.size_parse_stage = SP_DIGITS;
            end
          end
        end
        PH_BODY: begin
          body_valid           = 1'b1;
          body_byte            = data_byte;
          chunk_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            ctrl_next.phase           = PH_FOOTER;
            ctrl_next.line_char_count = 2'd0;
            ctrl_next.previous_was_cr = 1'b0;
          end
        end
        PH_FOOTER: begin
          if (lf) begin
            if (empty_line) begin
              ctrl_next.phase            = PH_SIZE;
              chunk_remaining_next       = '0;
              ctrl_next.size_parse_stage = SP_BLANKS;
              if (ctrl.last_chunk_seen) begin
                status                    = STAT_DONE;
                ctrl_next.last_chunk_seen = 1'b0;
              end
            end
            ctrl_next.line_char_count = 2'd0;
            ctrl_next.previous_was_cr = 1'b0;
          end else begin
            if (ctrl.line_char_count != 2'd2) begin
              ctrl_next.line_char_count = ctrl.line_char_count + 2'd1;
            end
            ctrl_next.previous_was_cr = (data_byte == CH_CR);
          end
        end
        default: begin
          ctrl_next.phase = PH_SIZE;
        end
      endcase
    end
  end

endmodule

[rtl/http_chunked_body_decoder_unit.sv]
// HTTP/1.1 chunked body decoder. Takes one received word per cycle on din
// (a data byte, or a close event) unless dout stalls, and gives exactly one
// result word per input word on dout: the payload byte with body_valid set
// while inside a chunk, and a status of running, message complete, truncated
// by close or size overflow. Sustained rate is one word per clock, no bubbles,
// while dout.ready holds; each word's result is written to the result register
// as the word is accepted, and din stays ready while the result register is
// empty or being taken. The rate is set by the single state update per word
// (hex size shift-in or chunk length down count), computed before dout.
module http_chunked_body_decoder_unit #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  hcbd_in_if.sink     din,
  hcbd_out_if.source  dout
);
  import hcbd_pkg::*;

  ctrl_t                ctrl;
  ctrl_t                ctrl_next;
  logic [SIZE_BITS-1:0] chunk_remaining;
  logic [SIZE_BITS-1:0] chunk_remaining_next;
  logic                 body_valid_next;
  logic [7:0]           body_byte_next;
  status_t              status_next;
  logic                 acc;

  assign din.ready = !dout.valid || dout.ready;
  assign acc       = din.valid && din.ready;

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .ctrl                 (ctrl),
    .chunk_remaining      (chunk_remaining),
    .action               (din.action),
    .data_byte            (din.data_byte),
    .ctrl_next            (ctrl_next),
    .chunk_remaining_next (chunk_remaining_next),
    .body_valid           (body_valid_next),
    .body_byte            (body_byte_next),
    .status               (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl            <= CTRL_RESET;
      chunk_remaining <= '0;
    end else if (acc) begin
      ctrl            <= ctrl_next;
      chunk_remaining <= chunk_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (acc) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      dout.body_valid <= body_valid_next;
      dout.body_byte  <= body_byte_next;
      dout.status     <= status_next;
    end
  end

  // a body word always yields a payload byte
  a_body_out: assert property (@(posedge clk) disable iff (rst)
    (acc && !din.action && ctrl.phase == PH_BODY) |=> (dout.valid && dout.body_valid))
    else $error("body word did not produce a payload byte");

  // close event brings everything back to reset
  a_close: assert property (@(posedge clk) disable iff (rst)
    (acc && din.action) |=>
      (dout.status == STAT_TRUNC && ctrl == CTRL_RESET && chunk_remaining == '0))
    else $error("close event did not reset the decoder");

  // decoder state only moves on an accepted word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !acc |=> ($stable(ctrl) && $stable(chunk_remaining)))
    else $error("decoder state changed without an input word");

  // a held result blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.ready) |-> !din.ready)
    else $error("input taken while result is stalled");

  // payload bytes never carry a non-running status
  a_body_status: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.body_valid) |-> (dout.status == STAT_RUN))
    else $error("payload byte with non-running status");

endmodule

[tb/sv/tb.sv]
module tb;
  import hcbd_pkg::*;

  localparam int unsigned SB = SIZE_BITS_DEF;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    status_t    status;
  } dec_word_t;

  // tracks the chunked framing state and queues the word each input should produce
  class chunked_decode_checker;
    phase_t          ph;
    logic            last_seen;
    logic [SB-1:0]   remaining;
    parse_stage_t    stage;
    logic [1:0]      line_cnt;
    logic            prev_cr;
    dec_word_t       pending[$];
    int              words_taken;
    int              mismatches;

    function new();
      clear_state();
      words_taken = 0;
      mismatches = 0;
    endfunction

    function void clear_state();
      ph = PH_SIZE;
      last_seen = 1'b0;
      remaining = '0;
      stage = SP_BLANKS;
      line_cnt = 2'd0;
      prev_cr = 1'b0;
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void take_word(logic act, logic [7:0] b);
      dec_word_t r;
      int d;
      r.body_valid = 1'b0;
      r.body_byte = 8'h00;
      r.status = STAT_RUN;
      words_taken++;
      if (act) begin
        clear_state();
        r.status = STAT_TRUNC;
      end else begin
        case (ph)
          PH_SIZE: begin
            d = digit_of(b);
            if (b == CH_LF) begin
              if (remaining == 0) begin
                ph = PH_FOOTER;
                last_seen = 1'b1;
              end else begin
                ph = PH_BODY;
              end
              stage = SP_BLANKS;
              line_cnt = 2'd0;
              prev_cr = 1'b0;
            end else if (stage == SP_BLANKS && (b == CH_SP || b == CH_TAB || b == CH_VT ||
                                                b == CH_FF || b == CH_CR)) begin
              // leading blank
            end else if (stage != SP_REST) begin
              if (d < 0) begin
                stage = SP_REST;
              end else if (remaining[SB-1 -: 4] != 4'd0) begin
                clear_state();
                r.status = STAT_OVFL;
              end else begin
                remaining = {remaining[SB-5:0], 4'(d)};
                stage = SP_DIGITS;
              end
            end
          end
          PH_BODY: begin
            r.body_valid = 1'b1;
            r.body_byte = b;
            remaining = remaining - SB'(1);
            if (remaining == 0) begin
              ph = PH_FOOTER;
              line_cnt = 2'd0;
              prev_cr = 1'b0;
            end
          end
          PH_FOOTER: begin
            if (b == CH_LF) begin
              if (line_cnt == 2'd0 || (line_cnt == 2'd1 && prev_cr)) begin
                ph = PH_SIZE;
                remaining = '0;
                stage = SP_BLANKS;
                if (last_seen) begin
                  r.status = STAT_DONE;
                  last_seen = 1'b0;
                end
              end
              line_cnt = 2'd0;
              prev_cr = 1'b0;
            end else begin
              if (line_cnt < 2'd2) line_cnt++;
              prev_cr = (b == CH_CR);
            end
          end
          default: ph = PH_SIZE;
        endcase
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic bv, logic [7:0] bb, logic [1:0] st);
      dec_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: valid=%0b byte=%02h status=%0d", bv, bb, st);
        return;
      end
      e = pending.pop_front();
      if (bv !== e.body_valid || bb !== e.body_byte || st !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected valid=%0b byte=%02h status=%0d, ",
                    "got valid=%0b byte=%02h status=%0d"},
                   e.body_valid, e.body_byte, e.status, bv, bb, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;

  chunked_decode_checker decoder_model;

  hcbd_in_if  din_if();
  hcbd_out_if dout_if();

  http_chunked_body_decoder_unit #(.SIZE_BITS(SB)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    dout_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready)
      decoder_model.check_result(dout_if.body_valid, dout_if.body_byte, dout_if.status);
  end

  // entered and left just after a falling edge; valid stays high between words unless an idle gap is drawn
  task automatic send_word(input logic act, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      din_if.valid <= 1'b0;
      @(negedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.action <= act;
    din_if.data_byte <= b;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    decoder_model.take_word(act, b);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(1'b0, s.getc(i));
  endtask

  task automatic send_eol();
    if ($urandom_range(0, 1)) send_text("\r\n");
    else send_text("\n");
  endtask

  task automatic drain();
    din_if.valid <= 1'b0;
    @(negedge clk);
    while (decoder_model.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_size_line(input logic [31:0] n, input bit digits);
    string s;
    int i;
    byte c;
    s = $sformatf("%0h", n);
    for (i = 0; i < s.len(); i++) begin
      c = s.getc(i);
      if (c >= "a" && c <= "f" && $urandom_range(0, 1)) s.putc(i, c - 8'd32);
    end
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 4))
        0: send_word(1'b0, CH_SP);
        1: send_word(1'b0, CH_TAB);
        2: send_word(1'b0, CH_VT);
        3: send_word(1'b0, CH_FF);
        default: send_word(1'b0, CH_CR);
      endcase
    end
    if (digits) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) send_text("0");
      send_text(s);
    end
    if ($urandom_range(0, 3) == 0) send_text(";ext=v1");
    send_eol();
  endtask

  task automatic send_trailer_line();
    int len;
    len = $urandom_range(1, 12);
    repeat (len) send_word(1'b0, 8'($urandom_range(8'h20, 8'h7e)));
    send_eol();
  endtask

  task automatic send_message();
    int nchunks;
    int len;
    nchunks = $urandom_range(0, 3);
    repeat (nchunks) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      send_size_line(len, 1'b1);
      repeat (len) send_word(1'b0, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) send_trailer_line();
      send_eol();
    end
    // last chunk, sometimes as a line without digits
    send_size_line(0, $urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 2)) send_trailer_line();
    send_eol();
  endtask

  task automatic send_noise();
    logic [31:0] big;
    int i;
    case ($urandom_range(0, 4))
      0: repeat ($urandom_range(1, 8)) send_word(1'b0, 8'($urandom_range(0, 255)));
      1: send_word(1'b1, 8'($urandom_range(0, 255)));
      2: begin
        // nine digits with a nonzero lead overflow the size register
        send_text($sformatf("%0h", $urandom_range(1, 15)));
        for (i = 0; i < 8; i++) send_text($sformatf("%0h", $urandom_range(0, 15)));
        send_eol();
      end
      3: begin
        big = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom() | 32'h8000_0000);
        send_size_line(big, 1'b1);
        repeat ($urandom_range(0, 6)) send_word(1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b1, 8'($urandom_range(0, 255)));
      end
      default: begin
        send_size_line($urandom_range(8, 20), 1'b1);
        repeat ($urandom_range(0, 7)) send_word(1'b0, 8'($urandom_range(0, 255)));
        send_word(1'b1, 8'($urandom_range(0, 255)));
      end
    endcase
    if ($urandom_range(0, 3) != 0) send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int k;
    int goal;
    clk = 1'b0;
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    din_if.valid = 1'b0;
    din_if.action = 1'b0;
    din_if.data_byte = 8'h00;
    dout_if.ready = 1'b0;
    decoder_model = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // close on an idle decoder, all leading blanks, then a two byte chunk
    send_word(1'b1, 8'hFF);
    send_text(" \t");
    send_word(1'b0, CH_VT);
    send_word(1'b0, CH_FF);
    send_word(1'b0, CH_CR);
    send_text("2\n");
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    send_text("\n");
    // no hex prefix: reads as zero, so this is the last chunk
    send_text("0x1\n\r\n");
    send_word(1'b1, 8'h00);
    send_text("100000000");
    // empty size line after the overflow, then an empty footer
    send_text("\n\n");

    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (k == 2) drain();
      goal = decoder_model.words_taken + 300;
      while (decoder_model.words_taken < goal) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_message();
      end
    end

    din_if.valid <= 1'b0;
    while (decoder_model.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (decoder_model.mismatches == 0 && decoder_model.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
